// ===== design/vstc_pkg.sv =====
// ============================================================================
// vstc_pkg: shared definitions for the scrolling text controller
// Opcodes, register indexes, reset values, widths and the command and
// configuration structures used between the controller's parts.
// ============================================================================
package vstc_pkg;

    // Default sizes of the tube chain and the text store.
    localparam int TUBE_COUNT_DEF = 8;
    localparam int TEXT_DEPTH_DEF = 64;

    // Frame geometry: twenty bytes, most significant byte first.
    localparam int WORD_W      = 20;
    localparam int BYTE_W      = 8;
    localparam int FRAME_BYTES = 20;
    localparam int FRAME_W     = FRAME_BYTES * BYTE_W;
    localparam int BYTE_CNT_W  = $clog2(FRAME_BYTES);

    // Field widths.
    localparam int OP_W      = 2;
    localparam int MS_W      = 16;
    localparam int ELAPSED_W = 8;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // Opcodes.
    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_TEXT   = 2'd1;
    localparam logic [OP_W-1:0] OP_DIRECT = 2'd2;
    localparam logic [OP_W-1:0] OP_BLANK  = 2'd3;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_DELAY     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_WORD    = 2'd3;

    // Register reset values.
    localparam logic [MS_W-1:0]   START_DELAY_RST   = 16'd2000;
    localparam logic [MS_W-1:0]   STEP_INTERVAL_RST = 16'd300;
    localparam logic [MS_W-1:0]   END_DELAY_RST     = 16'd2000;
    localparam logic [WORD_W-1:0] BLANK_WORD_RST    = 20'd0;

    // One classified command as it sits in the queue.
    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [WORD_W-1:0]    word;
        logic                 first;
        logic                 last;
        logic                 now;
        logic [ELAPSED_W-1:0] elapsed;
    } cmd_t;

    // Current configuration register values.
    typedef struct packed {
        logic [MS_W-1:0]   start_delay;
        logic [MS_W-1:0]   step_interval;
        logic [MS_W-1:0]   end_delay;
        logic [WORD_W-1:0] blank_word;
    } cfg_t;

endpackage

// ===== design/vstc_if.sv =====
// ============================================================================
// vstc_if: channel interfaces of the scrolling text controller
// Command input channel, frame byte output channel and register write
// channel, each with valid, ready and its payload.
// ============================================================================
interface vstc_cmd_if import vstc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      opcode;
    logic [WORD_W-1:0]    tube_word;
    logic                 first_word;
    logic                 last_word;
    logic                 commit_now;
    logic [ELAPSED_W-1:0] elapsed_ms;

    modport source(
        output valid, opcode, tube_word, first_word, last_word, commit_now, elapsed_ms,
        input  ready
    );
    modport sink(
        input  valid, opcode, tube_word, first_word, last_word, commit_now, elapsed_ms,
        output ready
    );
endinterface

interface vstc_frame_if import vstc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_byte;
    logic              frame_last;

    modport source(output valid, frame_byte, frame_last, input ready);
    modport sink(input valid, frame_byte, frame_last, output ready);
endinterface

interface vstc_cfg_if import vstc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== design/vstc_front.sv =====
// ============================================================================
// vstc_front: command intake
// Accepts command beats, classifies them by opcode and holds them in a
// short queue that the back end drains.
// ============================================================================
module vstc_front import vstc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    vstc_cmd_if.sink   cmd,
    output cmd_t       q_cmd,
    output logic       q_valid,
    input  logic       q_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    cmd_t             cmd_in;
    logic             push;
    logic             pop;

    // Flags that only matter for one opcode are cleared for the others.
    always_comb
    begin
        cmd_in.op      = cmd.opcode;
        cmd_in.word    = cmd.tube_word;
        cmd_in.first   = (cmd.opcode == OP_TEXT) && cmd.first_word;
        cmd_in.last    = (cmd.opcode == OP_TEXT) && cmd.last_word;
        cmd_in.now     = (cmd.opcode == OP_DIRECT) && cmd.commit_now;
        cmd_in.elapsed = cmd.elapsed_ms;
    end

    assign cmd.ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push      = cmd.valid && cmd.ready;
    assign q_valid   = (count_reg != '0);
    assign pop       = q_pop && q_valid;
    assign q_cmd     = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// ===== design/vstc_back.sv =====
// ============================================================================
// vstc_back: command execution
// Runs the scroll sequence, keeps the text store and the frame register,
// and streams committed frames through a registered output stage.
// ============================================================================
module vstc_back import vstc_pkg::*;
#(
    parameter int TUBE_COUNT = TUBE_COUNT_DEF,
    parameter int TEXT_DEPTH = TEXT_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  cmd_t         q_cmd,
    input  logic         q_valid,
    output logic         q_pop,
    input  cfg_t         cfg,
    vstc_frame_if.source frame
);

    localparam int AW = $clog2(TEXT_DEPTH);
    localparam int LW = $clog2(TEXT_DEPTH + 1);
    localparam int TW = $clog2(TUBE_COUNT);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_RST_RD  = 3'd1;
    localparam logic [2:0] S_RST_SH  = 3'd2;
    localparam logic [2:0] S_STEP_SH = 3'd3;
    localparam logic [2:0] S_COMMIT  = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic                  ret_rst_reg, ret_rst_next;
    logic [FRAME_W-1:0]    frame_reg, frame_next;
    logic [LW-1:0]         len_reg, len_next;
    logic [LW-1:0]         off_reg, off_next;
    logic [MS_W-1:0]       ms_reg, ms_next;
    logic                  scrolling_reg, scrolling_next;
    logic                  text_mode_reg, text_mode_next;
    logic [TW-1:0]         tube_reg, tube_next;
    logic [BYTE_CNT_W-1:0] bc_reg, bc_next;
    logic                  out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]     out_byte_reg, out_byte_next;
    logic                  out_last_reg, out_last_next;

    logic [WORD_W-1:0]     text_mem [TEXT_DEPTH];
    logic [WORD_W-1:0]     rd_data_reg;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;

    logic [MS_W:0]         ms_sum;
    logic [MS_W-1:0]       ms_sat;
    logic                  active;
    logic [LW:0]           end_sum;
    logic                  at_end;
    logic [LW-1:0]         base_len;
    logic                  room;
    logic                  tube_in_text;
    logic [WORD_W-1:0]     fill_word;
    logic [BYTE_W-1:0]     byte_sel;
    logic                  load_ok;
    logic                  restart;

    // Tick arithmetic: saturating millisecond count and scroll position.
    assign ms_sum   = {1'b0, ms_reg} + (MS_W + 1)'(q_cmd.elapsed);
    assign ms_sat   = ms_sum[MS_W] ? '1 : ms_sum[MS_W-1:0];
    assign active   = text_mode_reg && ({1'b0, len_reg} > (LW + 1)'(TUBE_COUNT));
    // The offset plus the tube count both tests the end of the text and
    // addresses the word that enters on the next scroll step.
    assign end_sum  = {1'b0, off_reg} + (LW + 1)'(TUBE_COUNT);
    assign at_end   = (end_sum >= {1'b0, len_reg});

    assign base_len     = q_cmd.first ? '0 : len_reg;
    assign room         = (base_len < LW'(TEXT_DEPTH));
    assign tube_in_text = (LW'(tube_reg) < len_reg);
    assign fill_word    = tube_in_text ? rd_data_reg : cfg.blank_word;
    assign load_ok      = !out_valid_reg || frame.ready;

    always_comb
    begin
        byte_sel = '0;
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            if (bc_reg == BYTE_CNT_W'(i))
            begin
                byte_sel = frame_reg[FRAME_W - 1 - BYTE_W * i -: BYTE_W];
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ret_rst_next   = ret_rst_reg;
        frame_next     = frame_reg;
        len_next       = len_reg;
        off_next       = off_reg;
        ms_next        = ms_reg;
        scrolling_next = scrolling_reg;
        text_mode_next = text_mode_reg;
        tube_next      = tube_reg;
        bc_next        = bc_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        restart        = 1'b0;

        if (out_valid_reg && frame.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    unique case (q_cmd.op)
                        OP_TICK:
                        begin
                            if (active)
                            begin
                                ms_next = ms_sat;
                                if (scrolling_reg)
                                begin
                                    if (at_end)
                                    begin
                                        if (ms_sat >= cfg.end_delay)
                                        begin
                                            restart = 1'b1;
                                        end
                                    end
                                    else if (ms_sat >= cfg.step_interval)
                                    begin
                                        ms_next    = '0;
                                        off_next   = off_reg + LW'(1);
                                        rd_en      = 1'b1;
                                        rd_addr    = end_sum[AW-1:0];
                                        state_next = S_STEP_SH;
                                    end
                                end
                                else if (ms_sat >= cfg.start_delay)
                                begin
                                    scrolling_next = 1'b1;
                                    ms_next        = '0;
                                end
                            end
                        end
                        OP_TEXT:
                        begin
                            if (q_cmd.first)
                            begin
                                off_next       = '0;
                                ms_next        = '0;
                                scrolling_next = 1'b0;
                                frame_next     = '0;
                                text_mode_next = 1'b0;
                            end
                            // The blank frame does not depend on the store, so
                            // the word is stored before that frame streams out.
                            if (room)
                            begin
                                wr_en    = 1'b1;
                                len_next = base_len + LW'(1);
                            end
                            else
                            begin
                                len_next = base_len;
                            end
                            if (q_cmd.first)
                            begin
                                bc_next      = '0;
                                ret_rst_next = q_cmd.last;
                                state_next   = S_COMMIT;
                            end
                            else if (q_cmd.last)
                            begin
                                restart = 1'b1;
                            end
                        end
                        OP_DIRECT:
                        begin
                            text_mode_next = 1'b0;
                            frame_next     = {frame_reg[FRAME_W-WORD_W-1:0], q_cmd.word};
                            if (q_cmd.now)
                            begin
                                bc_next      = '0;
                                ret_rst_next = 1'b0;
                                state_next   = S_COMMIT;
                            end
                        end
                        OP_BLANK:
                        begin
                            frame_next     = '0;
                            text_mode_next = 1'b0;
                            bc_next        = '0;
                            ret_rst_next   = 1'b0;
                            state_next     = S_COMMIT;
                        end
                    endcase
                end
            end
            S_RST_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = AW'(tube_reg);
                state_next = S_RST_SH;
            end
            S_RST_SH:
            begin
                frame_next = {frame_reg[FRAME_W-WORD_W-1:0], fill_word};
                if (tube_reg == TW'(TUBE_COUNT - 1))
                begin
                    text_mode_next = 1'b1;
                    bc_next        = '0;
                    ret_rst_next   = 1'b0;
                    state_next     = S_COMMIT;
                end
                else
                begin
                    tube_next  = tube_reg + TW'(1);
                    state_next = S_RST_RD;
                end
            end
            S_STEP_SH:
            begin
                frame_next   = {frame_reg[FRAME_W-WORD_W-1:0], rd_data_reg};
                bc_next      = '0;
                ret_rst_next = 1'b0;
                state_next   = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = byte_sel;
                    out_last_next  = (bc_reg == BYTE_CNT_W'(FRAME_BYTES - 1));
                    if (bc_reg == BYTE_CNT_W'(FRAME_BYTES - 1))
                    begin
                        if (ret_rst_reg)
                        begin
                            restart = 1'b1;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        bc_next = bc_reg + BYTE_CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Show the text from its start: clear the sequence and reload tubes.
        if (restart)
        begin
            off_next       = '0;
            ms_next        = '0;
            scrolling_next = 1'b0;
            tube_next      = '0;
            state_next     = S_RST_RD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_rst_reg   <= 1'b0;
            frame_reg     <= '0;
            len_reg       <= '0;
            off_reg       <= '0;
            ms_reg        <= '0;
            scrolling_reg <= 1'b0;
            text_mode_reg <= 1'b0;
            tube_reg      <= '0;
            bc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_rst_reg   <= ret_rst_next;
            frame_reg     <= frame_next;
            len_reg       <= len_next;
            off_reg       <= off_next;
            ms_reg        <= ms_next;
            scrolling_reg <= scrolling_next;
            text_mode_reg <= text_mode_next;
            tube_reg      <= tube_next;
            bc_reg        <= bc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    // Text store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            text_mem[base_len[AW-1:0]] <= q_cmd.word;
        end
        if (rd_en)
        begin
            rd_data_reg <= text_mem[rd_addr];
        end
    end

    assign frame.valid      = out_valid_reg;
    assign frame.frame_byte = out_byte_reg;
    assign frame.frame_last = out_last_reg;

endmodule

// ===== design/vfd_scrolling_text_controller.sv =====
// ============================================================================
// vfd_scrolling_text_controller: scrolling text marquee for a tube chain
// A commit streams 20 byte beats, one per cycle while the sink is ready.
// A restart reloads the tubes one at a time (one text store read, then
//   one shift per tube) and then streams the frame.
// Reset clears the frame, the text length and the scroll state and loads
//   the register reset values; the text store is not cleared.
// ============================================================================
module vfd_scrolling_text_controller import vstc_pkg::*;
#(
    parameter int TUBE_COUNT = TUBE_COUNT_DEF,
    parameter int TEXT_DEPTH = TEXT_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    vstc_cmd_if.sink     cmd,
    vstc_frame_if.source frame,
    vstc_cfg_if.sink     cfg
);

    // The design splits into an intake front end and an execution back end.
    // The front end classifies each command beat and parks it in a two-entry
    // queue, so a new command is taken while the back end is still streaming
    // a frame. The back end owns all sequence state: the 160-bit frame
    // register, the text store memory, the text length, the scroll offset,
    // the millisecond counter and the text mode flag.

    cfg_t cfg_reg, cfg_next;
    cmd_t q_cmd;
    logic q_valid;
    logic q_pop;

    // Register writes are always taken. The 16-bit registers keep the low
    // bits of the write data.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_START_DELAY:   cfg_next.start_delay   = cfg.data[MS_W-1:0];
                CFG_STEP_INTERVAL: cfg_next.step_interval = cfg.data[MS_W-1:0];
                CFG_END_DELAY:     cfg_next.end_delay     = cfg.data[MS_W-1:0];
                CFG_BLANK_WORD:    cfg_next.blank_word    = cfg.data[WORD_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_delay   <= START_DELAY_RST;
            cfg_reg.step_interval <= STEP_INTERVAL_RST;
            cfg_reg.end_delay     <= END_DELAY_RST;
            cfg_reg.blank_word    <= BLANK_WORD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Intake: accept, classify and queue command beats.
    vstc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_cmd   (q_cmd),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    // Execution: scroll sequence, text store, frame and byte stream.
    vstc_back #(
        .TUBE_COUNT (TUBE_COUNT),
        .TEXT_DEPTH (TEXT_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_cmd   (q_cmd),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .cfg     (cfg_reg),
        .frame   (frame)
    );

endmodule

// ===== tb/sv/marquee_frame_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// marquee_frame_checker: frame beat predictor and scoreboard
// Watches the command, frame and register channels of the scrolling text
// controller, predicts every frame beat that an accepted command causes and
// compares the beats leaving the block in order against those predictions.
// ============================================================================
module marquee_frame_checker import vstc_pkg::*;
#(
    parameter int TUBE_COUNT = TUBE_COUNT_DEF,
    parameter int TEXT_DEPTH = TEXT_DEPTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    vstc_cmd_if   cmd,
    vstc_frame_if frame,
    vstc_cfg_if   cfg,
    output int    fail_count,
    output int    pending_beats
);

    localparam int MS_CEILING  = 65535;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } frame_beat_t;

    frame_beat_t       expected_beats[$];
    cfg_t              regs;
    logic [FRAME_W-1:0] tube_frame;
    logic [WORD_W-1:0] text_words [TEXT_DEPTH];
    int unsigned       text_len;
    int unsigned       scroll_pos;
    int unsigned       ms_elapsed;
    bit                scroll_on;
    bit                showing_text;
    int                beat_count;

    task automatic report_mismatch(input string field, input logic [BYTE_W-1:0] got,
                                   input logic [BYTE_W-1:0] want);
        fail_count++;
        $display("%0t ns: beat %0d: %s is 0x%0h, predicted 0x%0h",
                 $time, beat_count, field, got, want);
    endtask

    // A new word enters at the right end and pushes the frame 20 bits left.
    function automatic void shift_in(input logic [WORD_W-1:0] w);
        tube_frame = {tube_frame[FRAME_W-WORD_W-1:0], w};
    endfunction

    function automatic void emit_frame();
        for (int i = 0; i < FRAME_BYTES; i++)
            expected_beats.push_back({tube_frame[FRAME_W-1-BYTE_W*i -: BYTE_W],
                                      i == FRAME_BYTES - 1});
    endfunction

    function automatic void blank_and_emit();
        tube_frame   = '0;
        showing_text = 1'b0;
        emit_frame();
    endfunction

    function automatic void restart_text();
        scroll_pos = 0;
        ms_elapsed = 0;
        scroll_on  = 1'b0;
        for (int t = 0; t < TUBE_COUNT; t++)
            shift_in(t < text_len ? text_words[t] : regs.blank_word);
        emit_frame();
        showing_text = 1'b1;
    endfunction

    function automatic void predict_frames(input logic [OP_W-1:0] op,
                                           input logic [WORD_W-1:0] word,
                                           input logic first, input logic last,
                                           input logic now,
                                           input logic [ELAPSED_W-1:0] elapsed);
        int unsigned last_pos;
        case (op)
            OP_TICK:
            begin
                if (showing_text && text_len > TUBE_COUNT)
                begin
                    last_pos   = text_len - TUBE_COUNT;
                    ms_elapsed = ms_elapsed + elapsed;
                    if (ms_elapsed > MS_CEILING)
                        ms_elapsed = MS_CEILING;
                    if (scroll_on)
                    begin
                        if (scroll_pos >= last_pos)
                        begin
                            if (ms_elapsed >= regs.end_delay)
                                restart_text();
                        end
                        else if (ms_elapsed >= regs.step_interval)
                        begin
                            ms_elapsed = 0;
                            scroll_pos++;
                            shift_in(text_words[(TUBE_COUNT - 1 + scroll_pos) % TEXT_DEPTH]);
                            emit_frame();
                        end
                    end
                    else if (ms_elapsed >= regs.start_delay)
                    begin
                        scroll_on  = 1'b1;
                        ms_elapsed = 0;
                    end
                end
            end
            OP_TEXT:
            begin
                if (first)
                begin
                    text_len   = 0;
                    scroll_pos = 0;
                    ms_elapsed = 0;
                    scroll_on  = 1'b0;
                    blank_and_emit();
                end
                if (text_len < TEXT_DEPTH)
                begin
                    text_words[text_len] = word;
                    text_len++;
                end
                if (last)
                    restart_text();
            end
            OP_DIRECT:
            begin
                showing_text = 1'b0;
                shift_in(word);
                if (now)
                    emit_frame();
            end
            default:
                blank_and_emit();
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            expected_beats.delete();
            regs         = '{START_DELAY_RST, STEP_INTERVAL_RST, END_DELAY_RST, BLANK_WORD_RST};
            tube_frame   = '0;
            text_len     = 0;
            scroll_pos   = 0;
            ms_elapsed   = 0;
            scroll_on    = 1'b0;
            showing_text = 1'b0;
            beat_count   = 0;
            fail_count   = 0;
        end
        else
        begin
            if (frame.valid && frame.ready)
            begin
                if (expected_beats.size() == 0)
                    report_mismatch("unpredicted beat", frame.frame_byte, '0);
                else
                begin
                    frame_beat_t want;
                    want = expected_beats.pop_front();
                    if (frame.frame_byte !== want.data)
                        report_mismatch("frame_byte", frame.frame_byte, want.data);
                    if (frame.frame_last !== want.last)
                        report_mismatch("frame_last", BYTE_W'(frame.frame_last),
                                        BYTE_W'(want.last));
                end
                beat_count++;
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_START_DELAY:   regs.start_delay   = cfg.data[MS_W-1:0];
                    CFG_STEP_INTERVAL: regs.step_interval = cfg.data[MS_W-1:0];
                    CFG_END_DELAY:     regs.end_delay     = cfg.data[MS_W-1:0];
                    default:           regs.blank_word    = cfg.data[WORD_W-1:0];
                endcase
            end
            if (cmd.valid && cmd.ready)
                predict_frames(cmd.opcode, cmd.tube_word, cmd.first_word, cmd.last_word,
                               cmd.commit_now, cmd.elapsed_ms);
        end
        pending_beats = expected_beats.size();
    end

endmodule

// ===== tb/sv/vfd_scrolling_text_controller_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// vfd_scrolling_text_controller_tb: testbench top for the marquee controller
// Drives commands and register writes into the controller, stalls the frame
// output at random and leaves prediction and checking to the frame checker.
// ============================================================================
module vfd_scrolling_text_controller_tb;
    import vstc_pkg::*;

    localparam int TUBES = TUBE_COUNT_DEF;
    localparam int DEPTH = TEXT_DEPTH_DEF;

    // A restart reloads every tube with a read and a shift each and then streams a
    // whole frame; twice that covers any command still in the back end.
    localparam int SETTLE_CYCLES = 2 * (2 * TUBES + FRAME_BYTES);

    // Length of the one deliberate output stall, long enough for the block
    // to fill up and push back on the command channel.
    localparam int LONG_HOLD_CYCLES = 300;

    localparam logic [MS_W-1:0] MS_MAX = '1;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending_beats;

    // When set, neither side inserts idle cycles.
    bit calm = 1'b0;
    // Raised by the stimulus, cleared by the output side once it has held off.
    bit long_hold_req = 1'b0;

    vstc_cmd_if   cmd_ch();
    vstc_frame_if frame_ch();
    vstc_cfg_if   cfg_ch();

    vfd_scrolling_text_controller DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .frame (frame_ch),
        .cfg   (cfg_ch)
    );

    marquee_frame_checker
    #(
        .TUBE_COUNT (TUBES),
        .TEXT_DEPTH (DEPTH)
    )
    checker_i
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd_ch),
        .frame         (frame_ch),
        .cfg           (cfg_ch),
        .fail_count    (fail_count),
        .pending_beats (pending_beats)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hard stop in case the block hangs. The slowest legal run is far below this.
    initial
    begin
        #20_000_000;
        $display("** vfd_scrolling_text_controller: FAILED **");
        $finish;
    end

    // Frame output side: ready follows random stall bursts, plus one long
    // hold-off on request, and stays high once the run has gone calm.
    initial
    begin
        frame_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                frame_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold_req = 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                frame_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                frame_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Offers one command beat and returns at the edge that accepts it. An
    // idle burst may come first; valid is never dropped and raised in one step.
    task automatic offer_cmd(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] word,
                             input logic first, input logic last, input logic now,
                             input logic [ELAPSED_W-1:0] elapsed);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.opcode     <= op;
        cmd_ch.tube_word  <= word;
        cmd_ch.first_word <= first;
        cmd_ch.last_word  <= last;
        cmd_ch.commit_now <= now;
        cmd_ch.elapsed_ms <= elapsed;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    // A text of random words; the flags that a text word ignores are random.
    task automatic send_text(input int len, input bit close);
        for (int i = 0; i < len; i++)
            offer_cmd(OP_TEXT, WORD_W'($urandom), i == 0, close && i == len - 1,
                      1'($urandom_range(0, 1)), ELAPSED_W'($urandom));
    endtask

    task automatic send_ticks(input int count, input int lo, input int hi);
        for (int i = 0; i < count; i++)
            offer_cmd(OP_TICK, WORD_W'($urandom), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      ELAPSED_W'($urandom_range(lo, hi)));
    endtask

    // Waits for every predicted beat. The extra edge first lets the checker
    // see the command accepted at the current edge.
    task automatic drain_output();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending_beats == 0);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    // Registers change only with the block idle: all beats out, and enough
    // further cycles for a tick or a text word that emits nothing.
    task automatic reconfigure(input cfg_t setting);
        drain_output();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_START_DELAY,   CFG_DATA_W'(setting.start_delay));
        write_reg(CFG_STEP_INTERVAL, CFG_DATA_W'(setting.step_interval));
        write_reg(CFG_END_DELAY,     CFG_DATA_W'(setting.end_delay));
        write_reg(CFG_BLANK_WORD,    setting.blank_word);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly short delays so that scrolling gets going within a few ticks,
    // now and then the extremes.
    function automatic logic [MS_W-1:0] pick_delay();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return MS_MAX;
        return MS_W'($urandom_range(0, 700));
    endfunction

    function automatic cfg_t random_setting();
        cfg_t s;
        s.start_delay   = pick_delay();
        s.step_interval = pick_delay();
        s.end_delay     = pick_delay();
        s.blank_word    = WORD_W'($urandom);
        return s;
    endfunction

    // Mostly complete texts followed by a run of ticks, which is what gets
    // the scroll sequence through its states; the rest is open texts,
    // stray words, direct digits, blanking and random noise.
    task automatic random_phase(input int quota, input bit with_pause);
        int  sent;
        int  pick;
        int  len;
        int  ticks;
        bit  paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < quota)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, TUBES)
                                                  : $urandom_range(TUBES + 1, TUBES + 16);
                ticks = $urandom_range(4, 30);
                send_text(len, 1'b1);
                send_ticks(ticks, 0, 255);
                sent += len + ticks;
            end
            else if (pick == 6)
            begin
                len = $urandom_range(1, 12);
                send_text(len, 1'b0);
                sent += len;
            end
            else if (pick == 7)
            begin
                // A word without the first flag extends whatever text is there.
                offer_cmd(OP_TEXT, WORD_W'($urandom), 1'b0, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), ELAPSED_W'($urandom));
                sent++;
            end
            else if (pick == 8)
            begin
                offer_cmd(OP_DIRECT, WORD_W'($urandom), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          ELAPSED_W'($urandom));
                sent++;
            end
            else
            begin
                offer_cmd(OP_W'($urandom), WORD_W'($urandom), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          ELAPSED_W'($urandom));
                sent++;
            end
            // Once per chosen phase the sender stops until the frame side is empty.
            if (with_pause && !paused && sent >= quota / 2)
            begin
                drain_output();
                paused = 1'b1;
            end
        end
    endtask

    initial
    begin
        cfg_t setting;

        rst_n             <= 1'b0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.opcode     <= OP_TICK;
        cmd_ch.tube_word  <= '0;
        cmd_ch.first_word <= 1'b0;
        cmd_ch.last_word  <= 1'b0;
        cmd_ch.commit_now <= 1'b0;
        cmd_ch.elapsed_ms <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= CFG_START_DELAY;
        cfg_ch.data       <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset register values. Blanking and direct
        // digits at the word extremes, then ticks that must be ignored: outside
        // text mode, and for texts no longer than the tube chain.
        offer_cmd(OP_BLANK,  '0,       1'b0, 1'b0, 1'b0, '0);
        offer_cmd(OP_DIRECT, '1,       1'b0, 1'b0, 1'b0, '0);
        offer_cmd(OP_DIRECT, '0,       1'b0, 1'b0, 1'b1, '0);
        offer_cmd(OP_DIRECT, 20'h5A5A5, 1'b1, 1'b1, 1'b1, '1);
        offer_cmd(OP_TICK,   '1,       1'b1, 1'b1, 1'b1, '1);
        // A stray word right after reset lands at the head of an empty store.
        offer_cmd(OP_TEXT,   '1,       1'b0, 1'b0, 1'b1, '1);
        // A one-word text carries both the first and the last flag.
        offer_cmd(OP_TEXT,   20'h12345, 1'b1, 1'b1, 1'b0, '0);
        offer_cmd(OP_TICK,   '0,       1'b0, 1'b0, 1'b0, '1);
        send_text(TUBES, 1'b1);
        offer_cmd(OP_TICK,   '1,       1'b0, 1'b0, 1'b0, '1);
        // A direct digit leaves text mode, so the next tick does nothing.
        offer_cmd(OP_DIRECT, 20'hA5A5A, 1'b0, 1'b0, 1'b0, '0);
        offer_cmd(OP_TICK,   '0,       1'b0, 1'b0, 1'b0, '1);
        offer_cmd(OP_BLANK,  '1,       1'b1, 1'b1, 1'b1, '1);

        // One word past the chain, full sequence at the reset timing: start
        // wait, one step, end wait and restart. A stray word then lengthens
        // the text while it keeps scrolling.
        send_text(TUBES + 1, 1'b1);
        offer_cmd(OP_TICK, '0, 1'b0, 1'b0, 1'b0, '0);
        send_ticks(18, 255, 255);
        offer_cmd(OP_TEXT, WORD_W'($urandom), 1'b0, 1'b0, 1'b0, '0);
        send_ticks(14, 200, 255);

        // All delays zero, so every tick acts. The text overflows the store and
        // the surplus words are dropped. The output side holds off for a long
        // stretch meanwhile, so the block fills and stalls its input.
        setting = '{16'd0, 16'd0, 16'd0, 20'hFFFFF};
        reconfigure(setting);
        long_hold_req = 1'b1;
        send_text(DEPTH + 2, 1'b1);
        send_ticks(8, 0, 255);

        // Random part under random settings; the first phase pauses midway
        // and the last one runs without any idling.
        for (int phase = 0; phase < 2; phase++)
        begin
            setting = random_setting();
            reconfigure(setting);
            if (phase == 1)
                calm = 1'b1;
            random_phase(30, phase == 0);
        end

        drain_output();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_beats == 0)
            $display("** vfd_scrolling_text_controller: PASSED **");
        else
            $display("** vfd_scrolling_text_controller: FAILED **");
        $finish;
    end

endmodule
